### rtl/swpd_pkg.sv
package swpd_pkg;

   // Storage and sample geometry.
   localparam int WINDOW_DEPTH  = 64;
   localparam int SAMPLE_BITS   = 16;

   localparam int ADDR_BITS     = $clog2(WINDOW_DEPTH);
   localparam int LEN_BITS      = $clog2(WINDOW_DEPTH + 1);

   // Configuration register fields.
   localparam int WL_FIELD_BITS = 7;
   localparam int THRESH_BITS   = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam int WL_RESET      = 16;
   localparam int THRESH_RESET  = 2304;

   // Datapath widths: window sum, deviation L*h - S, its magnitude and square,
   // the variance accumulator and the two sides of the final comparison.
   localparam int SUM_BITS      = SAMPLE_BITS + LEN_BITS;
   localparam int DEV_BITS      = SAMPLE_BITS + LEN_BITS + 1;
   localparam int MAG_BITS      = DEV_BITS - 1;
   localparam int SQ_BITS       = 2 * MAG_BITS;
   localparam int ACC_BITS      = SQ_BITS + LEN_BITS;
   localparam int SCALE_BITS    = LEN_BITS + 8;
   localparam int LHS_BITS      = SQ_BITS + SCALE_BITS;
   localparam int RHS_BITS      = ACC_BITS + THRESH_BITS;
   localparam int CMP_BITS      = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;

   // Peak flag codes.
   localparam logic signed [1:0] FLAG_NONE  = 2'sb00;
   localparam logic signed [1:0] FLAG_ABOVE = 2'sb01;
   localparam logic signed [1:0] FLAG_BELOW = 2'sb11;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_THRESHOLD     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MULT,
      ST_CMP,
      ST_FINISH
   } state_type;

endpackage

### rtl/swpd_req_if.sv
interface swpd_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [swpd_pkg::SAMPLE_BITS-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### rtl/swpd_rsp_if.sv
interface swpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [1:0]  peak_flag;
   logic               window_ready;

   modport source (output valid, output peak_flag, output window_ready, input ready);
   modport sink   (input valid, input peak_flag, input window_ready, output ready);
endinterface

### rtl/swpd_ram.sv
// Single-port-write, single-port-read RAM with a registered read.
module swpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sliding_window_peak_detector_top.sv
// Sliding-window peak detector.
//
// Each transaction on the req_ch channel carries one signed sample. Every
// sample produces exactly one transaction on the rsp_ch channel with a peak
// flag (0 none, +1 above the window mean, -1 below it) and a window_ready bit.
// Until window_length samples are stored, the response reports not ready and
// no peak. After that, each new sample is tested against the mean and the
// variance of the stored window, and then replaces the oldest sample.
// The block works on one sample at a time. A sample taken while the window
// is filling goes straight to the final state. A sample tested against a full
// window first has the variance sum read every stored sample once through the
// single read port of the sample RAM; then a multiply state forms both sides
// of the comparison and a compare state compares them. The response sits in an
// output register, so the next request is accepted while a response still
// waits; the block only holds in its final state when the previous response
// has not yet been taken.
// Reset (synchronous) empties the window and loads window_length = 16 and
// threshold_squared = 2304. Any write on the csr_ port also empties the window.
module sliding_window_peak_detector_top (
   input  logic                                    clock,
   input  logic                                    reset,
   swpd_req_if.sink                                req_ch,
   swpd_rsp_if.source                              rsp_ch,
   input  logic                                    csr_wr_en,
   input  logic [swpd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [swpd_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int ADDR_BITS = swpd_pkg::ADDR_BITS;
   localparam int LEN_BITS  = swpd_pkg::LEN_BITS;

   // Control state.
   swpd_pkg::state_type                          state_ff, state_in;
   logic [LEN_BITS-1:0]                          window_length_ff;
   logic [swpd_pkg::THRESH_BITS-1:0]             threshold_ff;
   logic [LEN_BITS-1:0]                          fill_count_ff;
   logic [ADDR_BITS-1:0]                         oldest_ff;
   logic signed [swpd_pkg::SUM_BITS-1:0]         sum_ff;
   logic [LEN_BITS-1:0]                          issue_ff;
   logic                                         v1_ff, v2_ff, v3_ff;
   logic                                         rsp_valid_ff;

   // Working registers for the current sample.
   logic signed [swpd_pkg::SAMPLE_BITS-1:0]      x_ff;
   logic [ADDR_BITS-1:0]                         wr_addr_ff;
   logic                                         tested_ff;
   logic signed [swpd_pkg::DEV_BITS-1:0]         dx_ff;
   logic [swpd_pkg::SQ_BITS-1:0]                 dsq_ff;
   logic [ADDR_BITS-1:0]                         idx1_ff;
   logic [swpd_pkg::MAG_BITS-1:0]                mag_ff;
   logic [swpd_pkg::SQ_BITS-1:0]                 sq_ff;
   logic [swpd_pkg::ACC_BITS-1:0]                acc_ff;
   logic signed [swpd_pkg::SAMPLE_BITS-1:0]      old_ff;
   logic [swpd_pkg::LHS_BITS-1:0]                lhs_ff;
   logic [swpd_pkg::RHS_BITS-1:0]                rhs_ff;
   logic signed [1:0]                            flag_ff;
   logic signed [1:0]                            rsp_flag_ff;
   logic                                         rsp_ready_ff;

   // Decoded control.
   logic                                         req_fire;
   logic                                         rd_en;
   logic                                         finish_fire;
   logic                                         window_full;
   logic [swpd_pkg::SAMPLE_BITS-1:0]             rd_data;

   // Combinational datapath.
   logic signed [swpd_pkg::DEV_BITS-1:0]         x_prod;
   logic signed [swpd_pkg::DEV_BITS-1:0]         h_prod;
   logic signed [swpd_pkg::DEV_BITS-1:0]         dev;
   logic [swpd_pkg::MAG_BITS-1:0]                dev_mag;
   logic [swpd_pkg::MAG_BITS-1:0]                dx_mag;
   logic [swpd_pkg::SCALE_BITS-1:0]              lhs_scale;
   logic                                         is_peak;
   logic [LEN_BITS-1:0]                          wl_in;
   logic [swpd_pkg::WL_FIELD_BITS-1:0]           wl_raw;
   logic [ADDR_BITS-1:0]                         oldest_next;

   assign window_full = (fill_count_ff >= window_length_ff);
   assign req_fire    = req_ch.valid && req_ch.ready;

   // Next state and handshake decode.
   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      rd_en        = 1'b0;
      finish_fire  = 1'b0;
      unique case (state_ff)
         swpd_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = window_full ? swpd_pkg::ST_SCAN : swpd_pkg::ST_FINISH;
            end
         end
         swpd_pkg::ST_SCAN: begin
            rd_en = 1'b1;
            if (issue_ff == window_length_ff - 1'b1) begin
               state_in = swpd_pkg::ST_DRAIN;
            end
         end
         swpd_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = swpd_pkg::ST_MULT;
            end
         end
         swpd_pkg::ST_MULT: begin
            state_in = swpd_pkg::ST_CMP;
         end
         swpd_pkg::ST_CMP: begin
            state_in = swpd_pkg::ST_FINISH;
         end
         swpd_pkg::ST_FINISH: begin
            // The response register must be free, or be emptied this cycle.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               finish_fire = 1'b1;
               state_in    = swpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swpd_pkg::ST_IDLE;
         end
      endcase
   end

   // Deviation of the incoming sample and of each stored sample from the
   // scaled mean, both as L*value - S.
   assign x_prod  = $signed({1'b0, window_length_ff}) * $signed(req_ch.sample);
   assign h_prod  = $signed({1'b0, window_length_ff}) * $signed(rd_data);
   assign dev     = h_prod - swpd_pkg::DEV_BITS'(sum_ff);
   assign dev_mag = dev[swpd_pkg::DEV_BITS-1] ?
                    swpd_pkg::MAG_BITS'(-dev) : swpd_pkg::MAG_BITS'(dev);
   assign dx_mag  = dx_ff[swpd_pkg::DEV_BITS-1] ?
                    swpd_pkg::MAG_BITS'(-dx_ff) : swpd_pkg::MAG_BITS'(dx_ff);
   assign lhs_scale = {window_length_ff, 8'h00};
   assign is_peak = swpd_pkg::CMP_BITS'(lhs_ff) > swpd_pkg::CMP_BITS'(rhs_ff);

   // The oldest pointer wraps at the configured window length.
   assign oldest_next = (swpd_pkg::LEN_BITS'(oldest_ff) + 1'b1 >= window_length_ff) ?
                        '0 : oldest_ff + 1'b1;

   // A window length of zero counts as one; larger than the RAM saturates.
   assign wl_raw = csr_wdata[swpd_pkg::WL_FIELD_BITS-1:0];
   always_comb begin
      if (wl_raw == '0) begin
         wl_in = LEN_BITS'(1);
      end else if (32'(wl_raw) > swpd_pkg::WINDOW_DEPTH) begin
         wl_in = LEN_BITS'(swpd_pkg::WINDOW_DEPTH);
      end else begin
         wl_in = LEN_BITS'(wl_raw);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= swpd_pkg::ST_IDLE;
         window_length_ff <= LEN_BITS'(swpd_pkg::WL_RESET);
         threshold_ff     <= swpd_pkg::THRESH_BITS'(swpd_pkg::THRESH_RESET);
         fill_count_ff    <= '0;
         oldest_ff        <= '0;
         sum_ff           <= '0;
         issue_ff         <= '0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= rd_en;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;

         if (req_fire) begin
            issue_ff <= '0;
         end else if (rd_en) begin
            issue_ff <= issue_ff + 1'b1;
         end

         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (finish_fire) begin
            if (tested_ff) begin
               sum_ff    <= sum_ff - swpd_pkg::SUM_BITS'(old_ff)
                                   + swpd_pkg::SUM_BITS'(x_ff);
               oldest_ff <= oldest_next;
            end else begin
               sum_ff        <= sum_ff + swpd_pkg::SUM_BITS'(x_ff);
               fill_count_ff <= fill_count_ff + 1'b1;
            end
         end

         // Write only while idle; not enforced. Each write restarts filling.
         if (csr_wr_en) begin
            unique case (swpd_pkg::csr_index_type'(csr_index))
               swpd_pkg::CSR_WINDOW_LENGTH: window_length_ff <= wl_in;
               swpd_pkg::CSR_THRESHOLD:
                  threshold_ff <= csr_wdata[swpd_pkg::THRESH_BITS-1:0];
            endcase
            fill_count_ff <= '0;
            oldest_ff     <= '0;
            sum_ff        <= '0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff      <= req_ch.sample;
         dx_ff     <= x_prod - swpd_pkg::DEV_BITS'(sum_ff);
         tested_ff <= window_full;
         wr_addr_ff <= window_full ? oldest_ff : fill_count_ff[ADDR_BITS-1:0];
         acc_ff    <= '0;
         flag_ff   <= swpd_pkg::FLAG_NONE;
      end

      // Variance pipeline: RAM read, deviation, square, accumulate.
      idx1_ff <= issue_ff[ADDR_BITS-1:0];
      if (v1_ff) begin
         mag_ff <= dev_mag;
         if (idx1_ff == wr_addr_ff) begin
            old_ff <= $signed(rd_data);
         end
      end
      sq_ff  <= mag_ff * mag_ff;
      dsq_ff <= dx_mag * dx_mag;
      if (v3_ff) begin
         acc_ff <= acc_ff + swpd_pkg::ACC_BITS'(sq_ff);
      end

      if (state_ff == swpd_pkg::ST_MULT) begin
         lhs_ff <= dsq_ff * lhs_scale;
         rhs_ff <= acc_ff * threshold_ff;
      end
      if (state_ff == swpd_pkg::ST_CMP && is_peak) begin
         flag_ff <= (!dx_ff[swpd_pkg::DEV_BITS-1] && dx_ff != '0) ?
                    swpd_pkg::FLAG_ABOVE : swpd_pkg::FLAG_BELOW;
      end

      if (finish_fire) begin
         rsp_flag_ff  <= flag_ff;
         rsp_ready_ff <= tested_ff;
      end
   end

   // Reads happen only while scanning and the single write only in the final
   // cycle, so the two ports never touch the same entry at once.
   swpd_ram #(
      .WIDTH (swpd_pkg::SAMPLE_BITS),
      .DEPTH (swpd_pkg::WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (finish_fire),
      .wr_addr (wr_addr_ff),
      .wr_data (x_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.peak_flag    = rsp_flag_ff;
   assign rsp_ch.window_ready = rsp_ready_ff;

endmodule

### rtl/swpd_checker.sv
module swpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  peak_flag,
   input logic        window_ready
);

   // A stalled response holds its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(peak_flag) && $stable(window_ready)))
      else $error("stalled response changed");

   // The flag code with only the sign bit set is never produced.
   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (peak_flag != 2'b10))
      else $error("illegal peak flag code");

   // No peak is reported while the window is still filling.
   a_fill_no_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !window_ready) |-> (peak_flag == 2'b00))
      else $error("peak reported before window was full");

   // Samples are processed one at a time: no request is taken right after one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

endmodule

bind sliding_window_peak_detector_top swpd_checker u_swpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .peak_flag    (rsp_ch.peak_flag),
   .window_ready (rsp_ch.window_ready)
);
